// File: src/gfm_pkg.sv
// Shared types and constants for the grid flag map block.
package gfm_pkg;

    localparam int CMD_W      = 3;
    localparam int IN_COORD_W = 8;
    localparam int COORD_W    = 7;
    localparam int SEL_W      = 2;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int SEEN_BIT   = 0;
    localparam int TUNNEL_BIT = 3;

    localparam logic [CMD_W-1:0] CMD_SET_BIT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OR      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECOMP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_DRAIN,
        ST_CLEAR
    } t_state;

    // Bounding box update request: clear resets to the map size, widen grows to (x, y).
    typedef struct packed {
        logic               clear;
        logic               widen;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_box_ctrl;

endpackage

// File: src/gfm_ram.sv
// Generic simple dual-port RAM with registered read.
module gfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gfm_box.sv
// Bounding box registers of seen cells.
module gfm_box
    import gfm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_box_ctrl          i_ctrl,
    input  logic [COORD_W-1:0] i_width,
    input  logic [COORD_W-1:0] i_height,
    output logic [COORD_W-1:0] o_left,
    output logic [COORD_W-1:0] o_top,
    output logic [COORD_W-1:0] o_right,
    output logic [COORD_W-1:0] o_bottom
);

    logic [COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic [COORD_W-1:0] n_left, n_top, n_right, n_bottom;

    always_comb begin
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        if (i_ctrl.clear) begin
            n_left   = i_width;
            n_top    = i_height;
            n_right  = '0;
            n_bottom = '0;
        end else if (i_ctrl.widen) begin
            if (i_ctrl.x <= r_left)   n_left   = i_ctrl.x;
            if (i_ctrl.x >= r_right)  n_right  = i_ctrl.x;
            if (i_ctrl.y <= r_top)    n_top    = i_ctrl.y;
            if (i_ctrl.y >= r_bottom) n_bottom = i_ctrl.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else begin
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
        end
    end

    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_right  = r_right;
    assign o_bottom = r_bottom;

endmodule

// File: src/grid_flag_map_with_bounding_box_unit.sv
// Grid flag map top level: cell store, command sequencer and box tracking.
// Cell commands (bit set/clear, read, write, or-merge): accept, a read-modify-write
//   in the modify state, result strobe on o_done the cycle after; a new request only once idle.
// Recompute: box clear in the modify state, one RAM read per cell in use, then a drain step.
// Clear: one RAM write per entry, 2^(XW+YW) entries (4096 by default), then the strobe.
// Reset and every config write start the same clearing pass; busy stays high meanwhile.
// o_done is a one-cycle strobe; results cannot be stalled.
module grid_flag_map_with_bounding_box_unit
    import gfm_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int FLAG_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [CMD_W-1:0]             i_cmd,
    input  logic signed [IN_COORD_W-1:0] i_cell_x,
    input  logic signed [IN_COORD_W-1:0] i_cell_y,
    input  logic [SEL_W-1:0]             i_flag_select,
    input  logic                         i_flag_value,
    input  logic [WORD_W-1:0]            i_word_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_done,
    output logic [WORD_W-1:0]            o_cell_flags,
    output logic                         o_on_map,
    output logic [COORD_W-1:0]           o_box_left,
    output logic [COORD_W-1:0]           o_box_top,
    output logic [COORD_W-1:0]           o_box_right,
    output logic [COORD_W-1:0]           o_box_bottom
);

    // Address is {row, column}; each coordinate gets a power-of-two slot.
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // zero counts as 1, anything above the maximum counts as the maximum
    function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] raw,
                                                    input int max_v);
        if (raw == '0) return COORD_W'(1);
        if (int'(raw) > max_v) return COORD_W'(max_v);
        return raw;
    endfunction

    t_state r_state, n_state;

    // config registers
    logic [COORD_W-1:0] r_map_width, r_map_height;
    logic [COORD_W-1:0] w_eff, h_eff;

    // latched request
    logic [CMD_W-1:0]      r_cmd;
    logic [COORD_W-1:0]    r_x, r_y;
    logic                  r_on;
    logic [SEL_W-1:0]      r_sel;
    logic                  r_fval;
    logic [FLAG_WIDTH-1:0] r_word;

    // sweep counters
    logic [AW-1:0]      r_clr;
    logic               r_report;
    logic [COORD_W-1:0] r_sx, r_sy;
    logic               r_pv;
    logic [COORD_W-1:0] r_px, r_py;

    // result registers
    logic               r_done;
    logic [WORD_W-1:0]  r_cell_flags;
    logic               r_on_map;
    logic               n_done;
    logic [WORD_W-1:0]  n_cell_flags;
    logic               n_on_map;

    logic                  accept;
    logic                  in_on;
    logic                  scan_last;
    logic                  clr_last;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [FLAG_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [FLAG_WIDTH-1:0] new_word, bit_mask;
    logic                  cell_we;
    t_box_ctrl             box_ctrl;

    assign w_eff  = eff_size(r_map_width, MAX_WIDTH);
    assign h_eff  = eff_size(r_map_height, MAX_HEIGHT);
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign in_on = !i_cell_x[IN_COORD_W-1] && !i_cell_y[IN_COORD_W-1]
                   && (i_cell_x[COORD_W-1:0] < w_eff) && (i_cell_y[COORD_W-1:0] < h_eff);

    assign scan_last = (r_sx == w_eff - COORD_W'(1)) && (r_sy == h_eff - COORD_W'(1));
    assign clr_last  = (r_clr == {AW{1'b1}});

    // --- next state ---
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd == CMD_CLEAR) ? ST_CLEAR : ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                n_state = (r_cmd == CMD_RECOMP) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // a config write re-creates the map: restart the clearing pass
        if (i_cfg_we) n_state = ST_CLEAR;
    end

    // --- read-modify-write of the addressed cell ---
    always_comb begin
        bit_mask = FLAG_WIDTH'(1) << r_sel;
        new_word = ram_rdata;
        cell_we  = 1'b0;
        case (r_cmd)
            CMD_SET_BIT: begin
                new_word = r_fval ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
                cell_we  = r_on;
            end
            CMD_WRITE: begin
                new_word = r_word;
                cell_we  = r_on;
            end
            CMD_OR: begin
                new_word = ram_rdata | r_word;
                cell_we  = r_on;
            end
            default: begin
                new_word = ram_rdata;
                cell_we  = 1'b0;
            end
        endcase
    end

    // --- datapath controls and result ---
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = {YW'(r_y), XW'(r_x)};
        ram_wdata    = new_word;
        ram_raddr    = {YW'(r_sy), XW'(r_sx)};
        box_ctrl     = '{clear: 1'b0, widen: 1'b0, x: r_x, y: r_y};
        n_done       = 1'b0;
        n_cell_flags = r_cell_flags;
        n_on_map     = r_on_map;
        case (r_state)
            ST_IDLE: begin
                // off-map coordinates read some cell; the result is forced to zero later
                ram_raddr = {YW'(i_cell_y[COORD_W-1:0]), XW'(i_cell_x[COORD_W-1:0])};
            end
            ST_MODIFY: begin
                ram_we       = cell_we;
                n_cell_flags = r_on ? WORD_W'(new_word) : '0;
                n_on_map     = r_on;
                n_done       = (r_cmd != CMD_RECOMP);
                box_ctrl.clear = (r_cmd == CMD_RECOMP);
                case (r_cmd)
                    CMD_SET_BIT: begin
                        box_ctrl.widen = r_on && r_fval
                                         && (r_sel == SEL_W'(SEEN_BIT)
                                             || r_sel == SEL_W'(TUNNEL_BIT));
                    end
                    CMD_WRITE, CMD_OR: begin
                        box_ctrl.widen = r_on && new_word[SEEN_BIT];
                    end
                    default: begin
                        box_ctrl.widen = 1'b0;
                    end
                endcase
            end
            ST_SCAN, ST_DRAIN: begin
                box_ctrl = '{clear: 1'b0, widen: r_pv && ram_rdata[SEEN_BIT],
                             x: r_px, y: r_py};
                n_done   = (r_state == ST_DRAIN);
            end
            ST_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = r_clr;
                ram_wdata      = '0;
                box_ctrl.clear = clr_last;
                if (clr_last && r_report) begin
                    n_done       = 1'b1;
                    n_cell_flags = '0;
                    n_on_map     = r_on;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // --- registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_map_width  <= 7'd64;
            r_map_height <= 7'd64;
            r_clr        <= '0;
            r_report     <= 1'b0;
            r_sx         <= '0;
            r_sy         <= '0;
            r_pv         <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pv    <= (r_state == ST_SCAN);

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH)  r_map_width  <= i_cfg_data;
                if (i_cfg_idx == CFG_HEIGHT) r_map_height <= i_cfg_data;
                r_clr    <= '0;
                r_report <= 1'b0;
            end else if (accept) begin
                r_clr    <= '0;
                r_report <= 1'b1;
            end else if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end

            if (r_state == ST_MODIFY) begin
                r_sx <= '0;
                r_sy <= '0;
            end else if (r_state == ST_SCAN) begin
                if (r_sx == w_eff - COORD_W'(1)) begin
                    r_sx <= '0;
                    r_sy <= r_sy + COORD_W'(1);
                end else begin
                    r_sx <= r_sx + COORD_W'(1);
                end
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_px         <= r_sx;
        r_py         <= r_sy;
        r_cell_flags <= n_cell_flags;
        r_on_map     <= n_on_map;
        if (accept) begin
            r_cmd  <= i_cmd;
            r_x    <= in_on ? i_cell_x[COORD_W-1:0] : '0;
            r_y    <= in_on ? i_cell_y[COORD_W-1:0] : '0;
            r_on   <= in_on;
            r_sel  <= i_flag_select;
            r_fval <= i_flag_value;
            r_word <= FLAG_WIDTH'(i_word_value);
        end
    end

    gfm_ram #(
        .WIDTH (FLAG_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gfm_box u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (box_ctrl),
        .i_width  (w_eff),
        .i_height (h_eff),
        .o_left   (o_box_left),
        .o_top    (o_box_top),
        .o_right  (o_box_right),
        .o_bottom (o_box_bottom)
    );

    assign o_done       = r_done;
    assign o_cell_flags = r_cell_flags;
    assign o_on_map     = r_on_map;

    // --- assertions ---
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_off_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_on_map) |-> (o_cell_flags == '0))
        else $error("off-map result carries a nonzero word");

    a_accept_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && i_cmd != CMD_CLEAR) |=> (r_state == ST_MODIFY))
        else $error("accepted cell request did not enter the modify cycle");

    a_write_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY && ram_we) |-> r_on)
        else $error("store written for an off-map cell");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_sx < w_eff && r_sy < h_eff))
        else $error("scan counter outside the map");

endmodule
